@@ sv/uer_pkg.sv @@
// Shared types and constants for the ultrasonic echo ranger.
package uer_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CFG_TRIGGER_TICKS = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_TICKS_PER_CM  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_TIMEOUT_TICKS = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_HOLDOFF_TICKS = 2'd3;

  localparam logic [7:0]  TRIGGER_TICKS_RST = 8'd10;
  localparam logic [7:0]  TICKS_PER_CM_RST  = 8'd58;
  localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd36000;
  localparam logic [15:0] HOLDOFF_TICKS_RST = 16'd5010;

  localparam logic [1:0] PH_TRIGGER = 2'd0;
  localparam logic [1:0] PH_WAIT    = 2'd1;
  localparam logic [1:0] PH_MEASURE = 2'd2;
  localparam logic [1:0] PH_HOLDOFF = 2'd3;

  typedef struct packed {
    logic [7:0]  trigger_ticks;
    logic [7:0]  ticks_per_cm;
    logic [15:0] timeout_ticks;
    logic [15:0] holdoff_ticks;
  } uer_cfg_t;

  typedef struct packed {
    logic [1:0]  phase;
    logic [15:0] phase_ticks;
    logic [15:0] echo_ticks;
    logic [7:0]  cm_fraction;
    logic [15:0] cm_count;
  } uer_state_t;

  typedef struct packed {
    logic        trigger_level;
    logic        result_valid;
    logic [15:0] distance_cm;
    logic        out_of_range;
  } uer_result_t;

endpackage

@@ sv/uer_cfg.sv @@
// Configuration register file of the echo ranger.
module uer_cfg
  import uer_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output uer_cfg_t            cfg_o
);

  uer_cfg_t cfg_q;
  uer_cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_TRIGGER_TICKS: cfg_d.trigger_ticks = cfg_data_i[7:0];
        CFG_TICKS_PER_CM:  cfg_d.ticks_per_cm  = cfg_data_i[7:0];
        CFG_TIMEOUT_TICKS: cfg_d.timeout_ticks = cfg_data_i;
        CFG_HOLDOFF_TICKS: cfg_d.holdoff_ticks = cfg_data_i;
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.trigger_ticks <= TRIGGER_TICKS_RST;
      cfg_q.ticks_per_cm  <= TICKS_PER_CM_RST;
      cfg_q.timeout_ticks <= TIMEOUT_TICKS_RST;
      cfg_q.holdoff_ticks <= HOLDOFF_TICKS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ sv/uer_step.sv @@
// Next-state and result logic for one microsecond tick.
module uer_step
  import uer_pkg::*;
(
  input  uer_cfg_t    cfg_i,
  input  uer_state_t  state_i,
  input  logic        echo_i,
  output uer_state_t  state_o,
  output uer_result_t result_o
);

  logic [7:0]  per;
  logic [7:0]  len;
  logic [8:0]  frac_inc;
  logic [15:0] echo_inc;
  logic [15:0] ticks_inc;
  logic [1:0]  holdoff_phase;
  uer_state_t  cur;

  assign per = (cfg_i.ticks_per_cm == 8'd0) ? 8'd1 : cfg_i.ticks_per_cm;
  assign len = (cfg_i.trigger_ticks == 8'd0) ? 8'd1 : cfg_i.trigger_ticks;
  assign holdoff_phase = (cfg_i.holdoff_ticks == 16'd0) ? PH_TRIGGER : PH_HOLDOFF;

  always_comb begin
    cur = state_i;
    if (state_i.phase == PH_WAIT && echo_i) begin
      cur.phase       = PH_MEASURE;
      cur.echo_ticks  = 16'd0;
      cur.cm_fraction = 8'd0;
      cur.cm_count    = 16'd0;
    end
  end

  assign frac_inc  = {1'b0, cur.cm_fraction} + 9'd1;
  assign echo_inc  = cur.echo_ticks + 16'd1;
  assign ticks_inc = cur.phase_ticks + 16'd1;

  always_comb begin
    state_o  = cur;
    result_o = '0;
    case (cur.phase)
      PH_WAIT: begin
        state_o = cur;
      end
      PH_MEASURE: begin
        if (echo_i) begin
          state_o.echo_ticks = echo_inc;
          if (frac_inc >= {1'b0, per}) begin
            state_o.cm_fraction = 8'd0;
            state_o.cm_count    = cur.cm_count + 16'd1;
          end else begin
            state_o.cm_fraction = frac_inc[7:0];
          end
          if (echo_inc >= cfg_i.timeout_ticks) begin
            result_o.result_valid = 1'b1;
            result_o.out_of_range = 1'b1;
            state_o.phase_ticks   = 16'd0;
            state_o.phase         = holdoff_phase;
          end
        end else begin
          result_o.result_valid = 1'b1;
          result_o.distance_cm  = cur.cm_count;
          state_o.phase_ticks   = 16'd0;
          state_o.phase         = holdoff_phase;
        end
      end
      PH_HOLDOFF: begin
        state_o.phase_ticks = ticks_inc;
        if (ticks_inc >= cfg_i.holdoff_ticks) begin
          state_o.phase_ticks = 16'd0;
          state_o.phase       = PH_TRIGGER;
        end
      end
      default: begin
        result_o.trigger_level = 1'b1;
        state_o.phase_ticks    = ticks_inc;
        if (ticks_inc >= {8'd0, len}) begin
          state_o.phase_ticks = 16'd0;
          state_o.phase       = PH_WAIT;
        end else begin
          state_o.phase = PH_TRIGGER;
        end
      end
    endcase
  end

endmodule

@@ sv/ultrasonic_echo_ranger.sv @@
// Top level of the ultrasonic echo ranger.
// Each input transaction is one microsecond tick carrying the sampled echo
// level; each tick yields exactly one output transaction with the trigger
// drive, a completion flag, the distance in centimetres and an out-of-range
// flag.
// An accepted tick is held in an input register, the phase logic runs in a
// single pass, and the result lands in an output register, from which the
// result is offered to the receiver.
// One tick is accepted every cycle unless the receiver stalls; the phase
// state is updated as each tick moves from the input to the output register.
// When the receiver stalls, the output register holds its transaction; an
// empty input register still takes one more tick before ready falls.
// Reset restores the default limits (10, 58, 36000 and 5010 ticks), puts the
// sequencer in the trigger phase with all counters cleared, and empties both
// registers. Configuration writes take effect on the next clock edge and
// should only be issued while no tick is in flight.
module ultrasonic_echo_ranger
  import uer_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                echo_level_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                trigger_level_o,
  output logic                result_valid_o,
  output logic [15:0]         distance_cm_o,
  output logic                out_of_range_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  uer_cfg_t    cfg;
  uer_state_t  state_q;
  uer_state_t  state_d;
  uer_result_t step_res;
  uer_result_t res_q;
  logic        in_vld_q;
  logic        echo_q;
  logic        out_vld_q;
  logic        advance;

  uer_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  uer_step u_step (
    .cfg_i    (cfg),
    .state_i  (state_q),
    .echo_i   (echo_q),
    .state_o  (state_d),
    .result_o (step_res)
  );

  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= '{phase: PH_TRIGGER, default: '0};
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
        state_q   <= state_d;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      echo_q <= echo_level_i;
    end
    if (advance) begin
      res_q <= step_res;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign trigger_level_o = res_q.trigger_level;
  assign result_valid_o  = res_q.result_valid;
  assign distance_cm_o   = res_q.distance_cm;
  assign out_of_range_o  = res_q.out_of_range;

endmodule

@@ dv/ultrasonic_echo_ranger_test.sv @@
// Self-checking testbench for the ultrasonic echo ranger, with a tick-level predictor.
`timescale 1ns / 1ps

module ultrasonic_echo_ranger_test
  import uer_pkg::*;
;

  localparam int SETTLE = 4;
  localparam logic [CfgIdxW-1:0] UNUSED_REG = CFG_TRIGGER_TICKS;

  typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_e;

  typedef struct packed {
    row_kind_e           kind;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;
    logic                echo;
    logic                typed;
    uer_result_t         want;
  } step_t;

  localparam uer_result_t QUIET     = '{1'b0, 1'b0, 16'd0, 1'b0};
  localparam uer_result_t PULSE     = '{1'b1, 1'b0, 16'd0, 1'b0};
  localparam uer_result_t TIMED_OUT = '{1'b0, 1'b1, 16'd0, 1'b1};
  localparam uer_result_t TWO_CM    = '{1'b0, 1'b1, 16'd2, 1'b0};
  localparam uer_result_t NONE      = '0;

  localparam int SCRIPT_LEN = 34;
  localparam step_t SCRIPT [SCRIPT_LEN] = '{
    '{ROW_TICK,  UNUSED_REG,        16'h0000, 1'b0, 1'b1, PULSE},
    '{ROW_TICK,  UNUSED_REG,        16'h0000, 1'b1, 1'b1, PULSE},
    '{ROW_WRITE, CFG_TRIGGER_TICKS, 16'h0000, 1'b0, 1'b0, NONE},
    '{ROW_TICK,  UNUSED_REG,        16'h0000, 1'b0, 1'b1, PULSE},
    '{ROW_WRITE, CFG_TICKS_PER_CM,  16'h0000, 1'b0, 1'b0, NONE},
    '{ROW_WRITE, CFG_TIMEOUT_TICKS, 16'h0000, 1'b0, 1'b0, NONE},
    '{ROW_WRITE, CFG_HOLDOFF_TICKS, 16'h0000, 1'b0, 1'b0, NONE},
    '{ROW_TICK,  UNUSED_REG,        16'h0000, 1'b0, 1'b1, QUIET},
    '{ROW_TICK,  UNUSED_REG,        16'h0000, 1'b1, 1'b1, TIMED_OUT},
    '{ROW_TICK,  UNUSED_REG,        16'h0000, 1'b0, 1'b1, PULSE},
    '{ROW_WRITE, CFG_TIMEOUT_TICKS, 16'hFFFF, 1'b0, 1'b0, NONE},
    '{ROW_TICK,  UNUSED_REG,        16'h0000, 1'b1, 1'b0, NONE},
    '{ROW_TICK,  UNUSED_REG,        16'h0000, 1'b1, 1'b0, NONE},
    '{ROW_TICK,  UNUSED_REG,        16'h0000, 1'b0, 1'b1, TWO_CM},
    '{ROW_WRITE, CFG_HOLDOFF_TICKS, 16'hFFFF, 1'b0, 1'b0, NONE},
    '{ROW_TICK,  UNUSED_REG,        16'h0000, 1'b0, 1'b1, PULSE},
    '{ROW_TICK,  UNUSED_REG,        16'h0000, 1'b1, 1'b0, NONE},
    '{ROW_TICK,  UNUSED_REG,        16'h0000, 1'b0, 1'b0, NONE},
    '{ROW_TICK,  UNUSED_REG,        16'h0000, 1'b0, 1'b1, QUIET},
    '{ROW_TICK,  UNUSED_REG,        16'h0000, 1'b1, 1'b1, QUIET},
    '{ROW_WRITE, CFG_HOLDOFF_TICKS, 16'h0001, 1'b0, 1'b0, NONE},
    '{ROW_TICK,  UNUSED_REG,        16'h0000, 1'b1, 1'b0, NONE},
    '{ROW_TICK,  UNUSED_REG,        16'h0000, 1'b0, 1'b0, NONE},
    '{ROW_WRITE, CFG_TRIGGER_TICKS, 16'h00FF, 1'b0, 1'b0, NONE},
    '{ROW_WRITE, CFG_TICKS_PER_CM,  16'h00FF, 1'b0, 1'b0, NONE},
    '{ROW_WRITE, CFG_TIMEOUT_TICKS, 16'h0003, 1'b0, 1'b0, NONE},
    '{ROW_TICK,  UNUSED_REG,        16'h0000, 1'b1, 1'b0, NONE},
    '{ROW_TICK,  UNUSED_REG,        16'h0000, 1'b1, 1'b0, NONE},
    '{ROW_TICK,  UNUSED_REG,        16'h0000, 1'b1, 1'b0, NONE},
    '{ROW_TICK,  UNUSED_REG,        16'h0000, 1'b0, 1'b0, NONE},
    '{ROW_TICK,  UNUSED_REG,        16'h0000, 1'b1, 1'b0, NONE},
    '{ROW_WRITE, CFG_TRIGGER_TICKS, 16'h0002, 1'b0, 1'b0, NONE},
    '{ROW_TICK,  UNUSED_REG,        16'h0000, 1'b0, 1'b0, NONE},
    '{ROW_TICK,  UNUSED_REG,        16'h0000, 1'b0, 1'b0, NONE}
  };

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                echo_level = 1'b0;
  logic                out_ready = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                in_ready;
  logic                out_valid;
  logic                trigger_level;
  logic                result_valid;
  logic [15:0]         distance_cm;
  logic                out_of_range;

  uer_cfg_t    ranger_cfg;
  uer_state_t  ranger_state;
  uer_result_t pending_readings [$];

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int noise_pct = 12;
  int mismatches = 0;
  int ticks_sent = 0;
  int results_checked = 0;
  int measurements = 0;
  int timeouts = 0;
  int settings_used = 1;
  logic echo_run_level = 1'b0;
  int echo_run_left = 0;

  ultrasonic_echo_ranger DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .echo_level_i   (echo_level),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .trigger_level_o(trigger_level),
    .result_valid_o (result_valid),
    .distance_cm_o  (distance_cm),
    .out_of_range_o (out_of_range),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic void enter_holdoff();
    ranger_state.phase_ticks = '0;
    ranger_state.phase = (ranger_cfg.holdoff_ticks == '0) ? PH_TRIGGER : PH_HOLDOFF;
  endfunction

  function automatic uer_result_t ranger_tick(input logic echo);
    uer_result_t r;
    logic [7:0]  per;
    logic [7:0]  len;
    r = '0;
    if (ranger_state.phase == PH_WAIT && echo) begin
      ranger_state.phase = PH_MEASURE;
      ranger_state.echo_ticks = '0;
      ranger_state.cm_fraction = '0;
      ranger_state.cm_count = '0;
    end
    case (ranger_state.phase)
      PH_WAIT: ;
      PH_MEASURE: begin
        if (echo) begin
          per = (ranger_cfg.ticks_per_cm == '0) ? 8'd1 : ranger_cfg.ticks_per_cm;
          ranger_state.echo_ticks = ranger_state.echo_ticks + 16'd1;
          if ({1'b0, ranger_state.cm_fraction} + 9'd1 >= {1'b0, per}) begin
            ranger_state.cm_fraction = '0;
            ranger_state.cm_count = ranger_state.cm_count + 16'd1;
          end else begin
            ranger_state.cm_fraction = ranger_state.cm_fraction + 8'd1;
          end
          if (ranger_state.echo_ticks >= ranger_cfg.timeout_ticks) begin
            r.result_valid = 1'b1;
            r.out_of_range = 1'b1;
            enter_holdoff();
          end
        end else begin
          r.result_valid = 1'b1;
          r.distance_cm = ranger_state.cm_count;
          enter_holdoff();
        end
      end
      PH_HOLDOFF: begin
        ranger_state.phase_ticks = ranger_state.phase_ticks + 16'd1;
        if (ranger_state.phase_ticks >= ranger_cfg.holdoff_ticks) begin
          ranger_state.phase_ticks = '0;
          ranger_state.phase = PH_TRIGGER;
        end
      end
      default: begin
        len = (ranger_cfg.trigger_ticks == '0) ? 8'd1 : ranger_cfg.trigger_ticks;
        r.trigger_level = 1'b1;
        ranger_state.phase_ticks = ranger_state.phase_ticks + 16'd1;
        if (ranger_state.phase_ticks >= {8'd0, len}) begin
          ranger_state.phase_ticks = '0;
          ranger_state.phase = PH_WAIT;
        end else begin
          ranger_state.phase = PH_TRIGGER;
        end
      end
    endcase
    return r;
  endfunction

  // Mostly runs of echo high and low, so that measurements complete, with some noise.
  function automatic logic next_echo();
    int hi_max;
    if ($urandom_range(99) < noise_pct) return 1'($urandom_range(1));
    if (echo_run_left == 0) begin
      hi_max = (ranger_cfg.timeout_ticks > 16'd600) ? 600
                                                     : int'(ranger_cfg.timeout_ticks) + 3;
      echo_run_level = ~echo_run_level;
      echo_run_left = echo_run_level ? $urandom_range(hi_max, 1) : $urandom_range(8, 1);
    end
    echo_run_left--;
    return echo_run_level;
  endfunction

  task automatic send_tick(input logic echo, input logic typed, input uer_result_t want);
    uer_result_t r;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid <= 1'b1;
    echo_level <= echo;
    do @(posedge clk); while (!in_ready);
    r = ranger_tick(echo);
    pending_readings.push_back(typed ? want : r);
    ticks_sent++;
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_register(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    case (idx)
      CFG_TRIGGER_TICKS: ranger_cfg.trigger_ticks = data[7:0];
      CFG_TICKS_PER_CM:  ranger_cfg.ticks_per_cm = data[7:0];
      CFG_TIMEOUT_TICKS: ranger_cfg.timeout_ticks = data;
      default:           ranger_cfg.holdoff_ticks = data;
    endcase
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    uer_result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (pending_readings.size() == 0) begin
        $error("Result transaction arrived with nothing expected.");
        mismatches++;
      end else begin
        exp_r = pending_readings.pop_front();
        results_checked++;
        if (exp_r.result_valid) measurements++;
        if (exp_r.out_of_range) timeouts++;
        if (trigger_level !== exp_r.trigger_level) begin
          $error("trigger_level: expected %0d, got %0d", exp_r.trigger_level, trigger_level);
          mismatches++;
        end
        if (result_valid !== exp_r.result_valid) begin
          $error("result_valid: expected %0d, got %0d", exp_r.result_valid, result_valid);
          mismatches++;
        end
        if (distance_cm !== exp_r.distance_cm) begin
          $error("distance_cm: expected %0d, got %0d", exp_r.distance_cm, distance_cm);
          mismatches++;
        end
        if (out_of_range !== exp_r.out_of_range) begin
          $error("out_of_range: expected %0d, got %0d", exp_r.out_of_range, out_of_range);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #1000000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int n_items;
    ranger_cfg = '{TRIGGER_TICKS_RST, TICKS_PER_CM_RST, TIMEOUT_TICKS_RST, HOLDOFF_TICKS_RST};
    ranger_state = '{PH_TRIGGER, 16'd0, 16'd0, 8'd0, 16'd0};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    tx_idle_pct = 24;
    rx_idle_pct = 47;
    for (int i = 0; i < SCRIPT_LEN; i++) begin
      if (SCRIPT[i].kind == ROW_WRITE) begin
        quiesce();
        write_register(SCRIPT[i].idx, SCRIPT[i].data);
      end else begin
        send_tick(SCRIPT[i].echo, SCRIPT[i].typed, SCRIPT[i].want);
      end
    end

    for (int p = 0; p < 6; p++) begin
      tx_idle_pct = (p < 2) ? 24 : (p < 4) ? 47 : 0;
      rx_idle_pct = (p < 2) ? 47 : (p < 4) ? 24 : 0;
      noise_pct = (p == 3) ? 1 : 12;
      n_items = (p == 3) ? 260 : 40;
      quiesce();
      case (p)
        1: begin
          write_register(CFG_TRIGGER_TICKS, 16'h0000);
          write_register(CFG_TICKS_PER_CM, 16'h0000);
          write_register(CFG_TIMEOUT_TICKS, 16'h0000);
          write_register(CFG_HOLDOFF_TICKS, 16'h0000);
        end
        3: begin
          write_register(CFG_TRIGGER_TICKS, 16'h00FF);
          write_register(CFG_TICKS_PER_CM, 16'h00FF);
          write_register(CFG_TIMEOUT_TICKS, 16'hFFFF);
          write_register(CFG_HOLDOFF_TICKS, 16'h0000);
        end
        default: begin
          write_register(CFG_TRIGGER_TICKS, 16'($urandom_range(4, 1)));
          write_register(CFG_TICKS_PER_CM, 16'($urandom_range(6, 1)));
          write_register(CFG_TIMEOUT_TICKS, 16'($urandom_range(40, 4)));
          write_register(CFG_HOLDOFF_TICKS, (p == 5) ? 16'hFFFF : 16'($urandom_range(6)));
        end
      endcase
      settings_used++;
      for (int i = 0; i < n_items; i++) send_tick(next_echo(), 1'b0, NONE);
    end

    quiesce();
    repeat (8) @(posedge clk);
    $display("Sent %0d ticks under %0d register settings with varied stalls on both sides.",
             ticks_sent, settings_used);
    $display("Checked %0d results: %0d completed measurements, %0d of them out of range.",
             results_checked, measurements, timeouts);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
